// ===== rtl/core/scratchpad_word_timing_table_top_defines.svh =====
// Assertion macros for the scratchpad word timing table.
`ifndef SCRATCHPAD_WORD_TIMING_TABLE_TOP_DEFINES_SVH
`define SCRATCHPAD_WORD_TIMING_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SWTT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SWTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/swtt_pkg.sv =====
package swtt_pkg;

    localparam int ENTRIES_DEF = 32;
    localparam int TICK_W      = 48;
    localparam int ADDR_W      = 32;
    localparam int LAT_W       = 16;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;

    localparam logic [LAT_W-1:0] LAT_RESET = 16'd1;

    localparam logic [OP_W-1:0] OP_READ  = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
    localparam logic [OP_W-1:0] OP_SYNC  = 3'd2;
    localparam logic [OP_W-1:0] OP_FILL  = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_MERGE,
        ST_UPDATE,
        ST_FILL,
        ST_FL_READ,
        ST_FL_EVAL,
        ST_FL_DONE
    } state_t;

    typedef enum logic [2:0] {
        EMIT_MISS,
        EMIT_FULL,
        EMIT_ACCESS,
        EMIT_FILL,
        EMIT_WB,
        EMIT_TOP
    } emit_t;

    typedef struct packed {
        logic  capture;
        logic  lookup;
        logic  merge;
        logic  update;
        logic  fill;
        logic  walk_start;
        logic  walk_next;
        logic  top_update;
        logic  clear;
        logic  emit;
        emit_t emit_sel;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic full;
        logic walk_valid;
        logic walk_dirty;
        logic walk_last;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/core/swtt_ram.sv =====
module swtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/swtt_ctrl.sv =====
module swtt_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [swtt_pkg::OP_W-1:0] opcode,
    input  swtt_pkg::stat_t          stat,
    output swtt_pkg::cmd_t           cmd
);

    swtt_pkg::state_t state_reg;
    swtt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swtt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.emit_sel = swtt_pkg::EMIT_MISS;
        in_ready     = 1'b0;
        case (state_reg)
            swtt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (opcode == swtt_pkg::OP_READ || opcode == swtt_pkg::OP_WRITE ||
                        opcode == swtt_pkg::OP_SYNC)
                    begin
                        state_next = swtt_pkg::ST_LOOKUP;
                    end
                    else if (opcode == swtt_pkg::OP_FILL)
                    begin
                        state_next = swtt_pkg::ST_FILL;
                    end
                    else if (opcode == swtt_pkg::OP_FLUSH)
                    begin
                        cmd.walk_start = 1'b1;
                        state_next     = swtt_pkg::ST_FL_READ;
                    end
                end
            end
            swtt_pkg::ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = swtt_pkg::ST_MERGE;
            end
            swtt_pkg::ST_MERGE:
            begin
                if (stat.hit)
                begin
                    cmd.merge  = 1'b1;
                    state_next = swtt_pkg::ST_UPDATE;
                end
                else if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = swtt_pkg::EMIT_MISS;
                    state_next   = swtt_pkg::ST_IDLE;
                end
            end
            swtt_pkg::ST_UPDATE:
            begin
                if (stat.out_free)
                begin
                    cmd.update   = 1'b1;
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = swtt_pkg::EMIT_ACCESS;
                    state_next   = swtt_pkg::ST_IDLE;
                end
            end
            swtt_pkg::ST_FILL:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = swtt_pkg::ST_IDLE;
                    if (stat.full)
                    begin
                        cmd.emit_sel = swtt_pkg::EMIT_FULL;
                    end
                    else
                    begin
                        cmd.fill     = 1'b1;
                        cmd.emit_sel = swtt_pkg::EMIT_FILL;
                    end
                end
            end
            swtt_pkg::ST_FL_READ:
            begin
                if (stat.walk_valid)
                begin
                    state_next = swtt_pkg::ST_FL_EVAL;
                end
                else if (stat.walk_last)
                begin
                    state_next = swtt_pkg::ST_FL_DONE;
                end
                else
                begin
                    cmd.walk_next = 1'b1;
                end
            end
            swtt_pkg::ST_FL_EVAL:
            begin
                // max update is idempotent while waiting on the output slot
                cmd.top_update = 1'b1;
                if (!stat.walk_dirty || stat.out_free)
                begin
                    if (stat.walk_dirty)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = swtt_pkg::EMIT_WB;
                    end
                    if (stat.walk_last)
                    begin
                        state_next = swtt_pkg::ST_FL_DONE;
                    end
                    else
                    begin
                        cmd.walk_next = 1'b1;
                        state_next    = swtt_pkg::ST_FL_READ;
                    end
                end
            end
            swtt_pkg::ST_FL_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = swtt_pkg::EMIT_TOP;
                    cmd.clear    = 1'b1;
                    state_next   = swtt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swtt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/swtt_datapath.sv =====
`include "scratchpad_word_timing_table_top_defines.svh"

module swtt_datapath #(
    parameter int ENTRIES = swtt_pkg::ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swtt_pkg::cmd_t                cmd,
    output swtt_pkg::stat_t               stat,
    input  logic [swtt_pkg::OP_W-1:0]     opcode,
    input  logic [swtt_pkg::ADDR_W-1:0]   word_address,
    input  logic [swtt_pkg::TICK_W-1:0]   current_tick,
    input  logic                          cfg_we,
    input  logic [swtt_pkg::LAT_W-1:0]    cfg_wdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [swtt_pkg::TICK_W-1:0]   ready_tick,
    output logic [swtt_pkg::STATUS_W-1:0] status,
    output logic [swtt_pkg::ADDR_W-1:0]   writeback_address,
    output logic                          writeback_valid,
    output logic                          last_result
);

    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int TICK_W  = swtt_pkg::TICK_W;
    localparam int ADDR_W  = swtt_pkg::ADDR_W;
    localparam int WORD_W  = ADDR_W + TICK_W;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    logic [swtt_pkg::OP_W-1:0]  op_reg;
    logic [ADDR_W-1:0]          addr_reg;
    logic [TICK_W-1:0]          now_reg;
    logic [swtt_pkg::LAT_W-1:0] lat_reg;

    logic [ADDR_W-1:0]  cam_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] dirty_reg;
    logic [CNT_W-1:0]   fill_cnt_reg;
    logic [IDX_W-1:0]   fill_idx;

    logic               match_any;
    logic [IDX_W-1:0]   match_idx;
    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;

    logic [TICK_W-1:0]  merged_reg;
    logic [ADDR_W-1:0]  ent_addr_reg;
    logic [IDX_W-1:0]   walk_idx_reg;
    logic [TICK_W-1:0]  top_reg;

    logic [IDX_W-1:0]   rd_addr;
    logic [WORD_W-1:0]  rd_data;
    logic [ADDR_W-1:0]  rd_ent_addr;
    logic [TICK_W-1:0]  rd_tick;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [WORD_W-1:0]  wr_data;

    logic [TICK_W:0]    acc_sum_full;
    logic [TICK_W:0]    fill_sum_full;
    logic [TICK_W-1:0]  acc_sum;
    logic [TICK_W-1:0]  fill_sum;
    logic [swtt_pkg::LAT_W-1:0] acc_lat;

    logic                          out_valid_reg;
    logic [TICK_W-1:0]             out_tick_reg;
    logic [swtt_pkg::STATUS_W-1:0] out_status_reg;
    logic [ADDR_W-1:0]             out_wb_addr_reg;
    logic                          out_wb_valid_reg;
    logic                          out_last_reg;
    logic                          out_free;

    assign fill_idx    = fill_cnt_reg[IDX_W-1:0];
    assign rd_ent_addr = rd_data[WORD_W-1:TICK_W];
    assign rd_tick     = rd_data[TICK_W-1:0];
    assign out_free    = !out_valid_reg || out_ready;

    // lowest matching index wins
    always_comb
    begin
        match_any = 1'b0;
        match_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && cam_reg[i] == addr_reg)
            begin
                match_any = 1'b1;
                match_idx = IDX_W'(i);
            end
        end
    end

    assign acc_lat       = (op_reg == swtt_pkg::OP_SYNC) ? '0 : lat_reg;
    assign acc_sum_full  = {1'b0, merged_reg} + {{(TICK_W + 1 - swtt_pkg::LAT_W){1'b0}}, acc_lat};
    assign fill_sum_full = {1'b0, now_reg} + {{(TICK_W + 1 - swtt_pkg::LAT_W){1'b0}}, lat_reg};
    assign acc_sum       = acc_sum_full[TICK_W] ? TICK_MAX : acc_sum_full[TICK_W-1:0];
    assign fill_sum      = fill_sum_full[TICK_W] ? TICK_MAX : fill_sum_full[TICK_W-1:0];

    assign rd_addr = cmd.lookup ? match_idx : walk_idx_reg;
    assign wr_en   = cmd.update || cmd.fill;
    assign wr_addr = cmd.fill ? fill_idx : hit_idx_reg;
    assign wr_data = cmd.fill ? {addr_reg, fill_sum} : {ent_addr_reg, acc_sum};

    swtt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            addr_reg <= word_address;
            now_reg  <= current_tick;
        end
        if (cmd.lookup)
        begin
            hit_idx_reg <= match_idx;
        end
        if (cmd.merge)
        begin
            merged_reg   <= (rd_tick < now_reg) ? now_reg : rd_tick;
            ent_addr_reg <= rd_ent_addr;
        end
        if (cmd.fill)
        begin
            cam_reg[fill_idx] <= addr_reg;
        end
        if (cmd.walk_start)
        begin
            top_reg <= '0;
        end
        else if (cmd.top_update && rd_tick > top_reg)
        begin
            top_reg <= rd_tick;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_reg      <= swtt_pkg::LAT_RESET;
            valid_reg    <= '0;
            dirty_reg    <= '0;
            fill_cnt_reg <= '0;
            hit_reg      <= 1'b0;
            walk_idx_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                lat_reg <= cfg_wdata;
            end
            if (cmd.lookup)
            begin
                hit_reg <= match_any;
            end
            if (cmd.walk_start)
            begin
                walk_idx_reg <= '0;
            end
            else if (cmd.walk_next)
            begin
                walk_idx_reg <= walk_idx_reg + 1'b1;
            end
            if (cmd.clear)
            begin
                valid_reg    <= '0;
                dirty_reg    <= '0;
                fill_cnt_reg <= '0;
            end
            else if (cmd.fill)
            begin
                valid_reg[fill_idx] <= 1'b1;
                dirty_reg[fill_idx] <= 1'b0;
                fill_cnt_reg        <= fill_cnt_reg + 1'b1;
            end
            else if (cmd.update && op_reg == swtt_pkg::OP_WRITE)
            begin
                dirty_reg[hit_idx_reg] <= 1'b1;
            end
        end
    end

    // output slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_tick_reg     <= '0;
            out_status_reg   <= swtt_pkg::STATUS_OK;
            out_wb_addr_reg  <= '0;
            out_wb_valid_reg <= 1'b0;
            out_last_reg     <= 1'b1;
            case (cmd.emit_sel)
                swtt_pkg::EMIT_MISS:
                begin
                    out_tick_reg   <= TICK_MAX;
                    out_status_reg <= swtt_pkg::STATUS_MISS;
                end
                swtt_pkg::EMIT_FULL:
                begin
                    out_tick_reg   <= TICK_MAX;
                    out_status_reg <= swtt_pkg::STATUS_NO_FREE;
                end
                swtt_pkg::EMIT_ACCESS:
                begin
                    out_tick_reg <= acc_sum;
                end
                swtt_pkg::EMIT_FILL:
                begin
                    out_tick_reg <= fill_sum;
                end
                swtt_pkg::EMIT_WB:
                begin
                    out_wb_addr_reg  <= rd_ent_addr;
                    out_wb_valid_reg <= 1'b1;
                    out_last_reg     <= 1'b0;
                end
                swtt_pkg::EMIT_TOP:
                begin
                    out_tick_reg <= top_reg;
                end
                default:
                begin
                    out_tick_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign ready_tick        = out_tick_reg;
    assign status            = out_status_reg;
    assign writeback_address = out_wb_addr_reg;
    assign writeback_valid   = out_wb_valid_reg;
    assign last_result       = out_last_reg;

    assign stat.hit        = hit_reg;
    assign stat.full       = (fill_cnt_reg == CNT_W'(ENTRIES));
    assign stat.walk_valid = valid_reg[walk_idx_reg];
    assign stat.walk_dirty = dirty_reg[walk_idx_reg];
    assign stat.walk_last  = (walk_idx_reg == IDX_W'(ENTRIES - 1));
    assign stat.out_free   = out_free;

    `SWTT_ASSERT_NOW(a_emit_slot_free, cmd.emit, out_free, "result loaded over a pending item")
    `SWTT_ASSERT_NOW(a_fill_not_full, cmd.fill, !stat.full, "fill into a full table")
    `SWTT_ASSERT_NOW(a_count_matches_valid, 1'b1,
        $countones(valid_reg) == int'(fill_cnt_reg), "fill count out of step with valid bits")
    `SWTT_ASSERT_NEXT(a_clear_empties, cmd.clear,
        fill_cnt_reg == '0 && valid_reg == '0 && dirty_reg == '0, "flush left entries behind")

endmodule

// ===== rtl/core/scratchpad_word_timing_table_top.sv =====
// Fully associative table of ENTRIES word entries with ready ticks. Inputs are
// taken only while the controller is idle; the result is held in an output
// register, so the next item is taken while a result waits. A fill is accepted,
// then written or reported full; a read/write/sync hit goes through accept, address
// match, entry read from the tick RAM, max then saturating add and write-back; a
// miss reports after the address match; undefined opcodes are only accepted.
// Flush walks the entries over the single read port of the entry RAM and emits
// one item per dirty entry plus a final one. Output stalls hold the controller.
module scratchpad_word_timing_table_top #(
    parameter int ENTRIES = swtt_pkg::ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [swtt_pkg::OP_W-1:0]     opcode,
    input  logic [swtt_pkg::ADDR_W-1:0]   word_address,
    input  logic [swtt_pkg::TICK_W-1:0]   current_tick,
    input  logic                          cfg_we,
    input  logic [swtt_pkg::LAT_W-1:0]    cfg_wdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [swtt_pkg::TICK_W-1:0]   ready_tick,
    output logic [swtt_pkg::STATUS_W-1:0] status,
    output logic [swtt_pkg::ADDR_W-1:0]   writeback_address,
    output logic                          writeback_valid,
    output logic                          last_result
);

    swtt_pkg::cmd_t  cmd;
    swtt_pkg::stat_t stat;

    swtt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .stat     (stat),
        .cmd      (cmd)
    );

    swtt_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .opcode            (opcode),
        .word_address      (word_address),
        .current_tick      (current_tick),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .ready_tick        (ready_tick),
        .status            (status),
        .writeback_address (writeback_address),
        .writeback_valid   (writeback_valid),
        .last_result       (last_result)
    );

endmodule

// ===== sim/tb_scratchpad_word_timing_table_top.sv =====
module tb_scratchpad_word_timing_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    import swtt_pkg::*;

    localparam int DEPTH         = ENTRIES_DEF;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 80;
    localparam int RANDOM_ITEMS  = 400;
    localparam int PHASE_ITEMS   = 60;
    localparam int IDLE_MAX      = 18;
    localparam int MAX_REPORTS   = 40;

    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    localparam logic [TICK_W-1:0] TICK_SAT = '1;
    localparam logic [LAT_W-1:0]  LAT_MAX  = '1;

    typedef struct packed {
        logic [TICK_W-1:0]   tick;
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   wb_addr;
        logic                wb_valid;
        logic                last;
    } table_result_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [ADDR_W-1:0]   addr;
        logic [TICK_W-1:0]   now;
        logic                typed;
        logic [TICK_W-1:0]   exp_tick;
        logic [STATUS_W-1:0] exp_status;
    } stim_row_t;

    localparam int N_ROWS = 21;

    // typed rows carry their result; the rest go through the shadow table
    stim_row_t stim_rows [N_ROWS] = '{
        '{OP_READ,   32'h0000_0000, 48'h0,              1'b1, TICK_SAT,     STATUS_MISS},
        '{OP_FLUSH,  32'h0F0F_0F0F, 48'h0F0F_0F0F_0F0F, 1'b1, 48'h0,        STATUS_OK},
        '{OP_FILL,   32'h0000_0000, 48'h0,              1'b1, 48'h1,        STATUS_OK},
        '{OP_FILL,   32'hFFFF_FFFF, TICK_SAT,           1'b1, TICK_SAT,     STATUS_OK},
        '{OP_FILL,   32'h0000_0000, 48'd100,            1'b1, 48'd101,      STATUS_OK},
        '{OP_READ,   32'h0000_0000, 48'd5,              1'b0, 48'h0,        STATUS_OK},
        '{OP_WRITE,  32'hFFFF_FFFF, 48'h0,              1'b0, 48'h0,        STATUS_OK},
        '{OP_SYNC,   32'h0000_0000, 48'd3,              1'b0, 48'h0,        STATUS_OK},
        '{OP_SYNC,   32'h1234_5678, 48'd7,              1'b1, TICK_SAT,     STATUS_MISS},
        '{OP_WRITE,  32'h0000_0000, 48'hAAAA_AAAA_AAAA, 1'b0, 48'h0,        STATUS_OK},
        '{OP_WRITE,  32'h5555_5555, 48'h5555_5555_5555, 1'b1, TICK_SAT,     STATUS_MISS},
        '{OP_RSVD_5, 32'h5555_5555, 48'h5555_5555_5555, 1'b0, 48'h0,        STATUS_OK},
        '{OP_RSVD_6, 32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA, 1'b0, 48'h0,        STATUS_OK},
        '{OP_RSVD_7, 32'hFFFF_FFFF, TICK_SAT,           1'b0, 48'h0,        STATUS_OK},
        '{OP_FILL,   32'hA5A5_A5A5, 48'h7FFF_FFFF_FFFF, 1'b0, 48'h0,        STATUS_OK},
        '{OP_READ,   32'hA5A5_A5A5, 48'h0,              1'b0, 48'h0,        STATUS_OK},
        '{OP_FLUSH,  32'hF0F0_F0F0, 48'hF0F0_F0F0_F0F0, 1'b0, 48'h0,        STATUS_OK},
        '{OP_READ,   32'h0000_0000, 48'h0,              1'b1, TICK_SAT,     STATUS_MISS},
        '{OP_FILL,   32'h8000_0000, 48'hFFFF_FFFF_FFFE, 1'b1, TICK_SAT,     STATUS_OK},
        '{OP_WRITE,  32'h8000_0000, 48'h0,              1'b0, 48'h0,        STATUS_OK},
        '{OP_FLUSH,  32'h3C3C_3C3C, 48'h3C3C_3C3C_3C3C, 1'b0, 48'h0,        STATUS_OK}
    };

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OP_W-1:0]     opcode;
    logic [ADDR_W-1:0]   word_address;
    logic [TICK_W-1:0]   current_tick;
    logic                cfg_we;
    logic [LAT_W-1:0]    cfg_wdata;
    logic                out_valid;
    logic                out_ready;
    logic [TICK_W-1:0]   ready_tick;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   writeback_address;
    logic                writeback_valid;
    logic                last_result;

    logic [ADDR_W-1:0] sh_addr  [DEPTH];
    logic [TICK_W-1:0] sh_tick  [DEPTH];
    logic              sh_valid [DEPTH];
    logic              sh_dirty [DEPTH];
    int                sh_free;
    logic [LAT_W-1:0]  sh_latency;

    table_result_t     pending_results[$];
    logic [ADDR_W-1:0] filled_addrs[$];

    int in_idle_max  = IDLE_MAX;
    int out_idle_max = IDLE_MAX;
    int cycle_count  = 0;
    int mismatches   = 0;
    int n_items      = 0;
    int n_results    = 0;
    int n_flush      = 0;
    int n_wb         = 0;
    int n_miss       = 0;
    int n_full       = 0;
    int n_cfg        = 0;

    scratchpad_word_timing_table_top u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .opcode            (opcode),
        .word_address      (word_address),
        .current_tick      (current_tick),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .ready_tick        (ready_tick),
        .status            (status),
        .writeback_address (writeback_address),
        .writeback_valid   (writeback_valid),
        .last_result       (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [TICK_W-1:0] tick_add_sat(input logic [TICK_W-1:0] t,
                                                       input logic [LAT_W-1:0] lat);
        logic [TICK_W:0] sum;
        sum = {1'b0, t} + {{(TICK_W + 1 - LAT_W){1'b0}}, lat};
        return sum[TICK_W] ? TICK_SAT : sum[TICK_W-1:0];
    endfunction

    function automatic table_result_t make_result(input logic [TICK_W-1:0] tick,
                                                  input logic [STATUS_W-1:0] st,
                                                  input logic [ADDR_W-1:0] wb_addr,
                                                  input logic wb_valid,
                                                  input logic last);
        table_result_t r;
        r.tick     = tick;
        r.status   = st;
        r.wb_addr  = wb_addr;
        r.wb_valid = wb_valid;
        r.last     = last;
        return r;
    endfunction

    task automatic clear_shadow();
        for (int i = 0; i < DEPTH; i++)
        begin
            sh_addr[i]  = '1;
            sh_tick[i]  = '0;
            sh_valid[i] = 1'b0;
            sh_dirty[i] = 1'b0;
        end
        sh_free = DEPTH;
    endtask

    // Applies one item to the shadow table; queues its results when record is set.
    task automatic shadow_table_step(input logic [OP_W-1:0] op,
                                     input logic [ADDR_W-1:0] addr,
                                     input logic [TICK_W-1:0] now,
                                     input bit record);
        int                hit;
        int                idx;
        logic [TICK_W-1:0] top;
        table_result_t     res[$];
        hit = -1;
        top = '0;
        case (op)
            OP_READ, OP_WRITE, OP_SYNC:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (hit < 0 && sh_valid[i] && sh_addr[i] == addr)
                        hit = i;
                end
                if (hit < 0)
                begin
                    res.insert(res.size(), make_result(TICK_SAT, STATUS_MISS, '0, 1'b0, 1'b1));
                    n_miss++;
                end
                else
                begin
                    if (sh_tick[hit] < now)
                        sh_tick[hit] = now;
                    if (op != OP_SYNC)
                        sh_tick[hit] = tick_add_sat(sh_tick[hit], sh_latency);
                    if (op == OP_WRITE)
                        sh_dirty[hit] = 1'b1;
                    res.insert(res.size(),
                               make_result(sh_tick[hit], STATUS_OK, '0, 1'b0, 1'b1));
                end
            end
            OP_FILL:
            begin
                if (sh_free == 0)
                begin
                    res.insert(res.size(),
                               make_result(TICK_SAT, STATUS_NO_FREE, '0, 1'b0, 1'b1));
                    n_full++;
                end
                else
                begin
                    idx = DEPTH - sh_free;
                    sh_addr[idx]  = addr;
                    sh_valid[idx] = 1'b1;
                    sh_dirty[idx] = 1'b0;
                    sh_tick[idx]  = tick_add_sat(now, sh_latency);
                    sh_free--;
                    res.insert(res.size(),
                               make_result(sh_tick[idx], STATUS_OK, '0, 1'b0, 1'b1));
                end
            end
            OP_FLUSH:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (sh_valid[i])
                    begin
                        if (sh_tick[i] > top)
                            top = sh_tick[i];
                        if (sh_dirty[i])
                        begin
                            res.insert(res.size(),
                                       make_result('0, STATUS_OK, sh_addr[i], 1'b1, 1'b0));
                            n_wb++;
                        end
                    end
                end
                res.insert(res.size(), make_result(top, STATUS_OK, '0, 1'b0, 1'b1));
                clear_shadow();
                n_flush++;
            end
            default:
                ;
        endcase
        if (record)
        begin
            foreach (res[k])
                pending_results.insert(pending_results.size(), res[k]);
        end
    endtask

    task automatic report_mismatch(input string field, input logic [TICK_W-1:0] exp_v,
                                   input logic [TICK_W-1:0] act_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, act_v);
    endtask

    task automatic check_result();
        table_result_t got;
        table_result_t want;
        got = make_result(ready_tick, status, writeback_address, writeback_valid, last_result);
        n_results++;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: unexpected result, expected none, got tick %0h status %0h",
                         $time, got.tick, got.status);
        end
        else
        begin
            want = pending_results.pop_front();
            if (want.tick !== got.tick)
                report_mismatch("ready_tick", want.tick, got.tick);
            if (want.status !== got.status)
                report_mismatch("status", want.status, got.status);
            if (want.wb_addr !== got.wb_addr)
                report_mismatch("writeback_address", want.wb_addr, got.wb_addr);
            if (want.wb_valid !== got.wb_valid)
                report_mismatch("writeback_valid", want.wb_valid, got.wb_valid);
            if (want.last !== got.last)
                report_mismatch("last_result", want.last, got.last);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_result();
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("** scratchpad_word_timing_table_top: FAILED **");
            $finish;
        end
    end

    // result side: random stall before each result
    initial
    begin
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = $urandom_range(0, out_idle_max);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [TICK_W-1:0] now, input bit record);
        int gap;
        gap = $urandom_range(0, in_idle_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        word_address <= addr;
        current_tick <= now;
        do @(posedge clk); while (!in_ready);
        shadow_table_step(op, addr, now, record);
        if (op <= OP_FLUSH)
            n_items++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_latency(input logic [LAT_W-1:0] lat);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= lat;
        @(posedge clk);
        cfg_we     <= 1'b0;
        sh_latency = lat;
        n_cfg++;
    endtask

    function automatic logic [TICK_W-1:0] rand_tick();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       return TICK_W'($urandom_range(0, 5000));
            1:       return r[TICK_W-1:0];
            2:       return TICK_SAT - TICK_W'($urandom_range(0, 70000));
            default: return {8'h00, r[TICK_W-9:0]};
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_filled();
        if (filled_addrs.size() == 0 || $urandom_range(0, 99) < 15)
            return rand_addr();
        return filled_addrs[$urandom_range(0, filled_addrs.size() - 1)];
    endfunction

    function automatic logic [OP_W-1:0] OP_OP_RSVD_PICK();
        return OP_W'($urandom_range(OP_RSVD_5, OP_RSVD_7));
    endfunction

    task automatic send_noise();
        send_item(OP_OP_RSVD_PICK(), rand_addr(), rand_tick(), 1'b1);
    endtask

    task automatic run_episode(input int n_fill, input bit write_all, input bit do_flush);
        logic [ADDR_W-1:0] a;
        logic [OP_W-1:0]   op;
        int                n_acc;
        in_idle_max  = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
        out_idle_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
        for (int i = 0; i < n_fill; i++)
        begin
            if (filled_addrs.size() != 0 && $urandom_range(0, 5) == 0)
                a = filled_addrs[$urandom_range(0, filled_addrs.size() - 1)];
            else
                a = rand_addr();
            send_item(OP_FILL, a, rand_tick(), 1'b1);
            filled_addrs.insert(filled_addrs.size(), a);
            if ($urandom_range(0, 19) == 0)
                send_noise();
        end
        if (write_all)
        begin
            foreach (filled_addrs[k])
                send_item(OP_WRITE, filled_addrs[k], rand_tick(), 1'b1);
        end
        n_acc = $urandom_range(2, 14);
        for (int i = 0; i < n_acc; i++)
        begin
            case ($urandom_range(0, 2))
                0:       op = OP_READ;
                1:       op = OP_WRITE;
                default: op = OP_SYNC;
            endcase
            send_item(op, pick_filled(), rand_tick(), 1'b1);
            if ($urandom_range(0, 9) == 0)
            begin
                a = rand_addr();
                send_item(OP_FILL, a, rand_tick(), 1'b1);
                filled_addrs.insert(filled_addrs.size(), a);
            end
            if ($urandom_range(0, 19) == 0)
                send_noise();
        end
        if (do_flush)
        begin
            send_item(OP_FLUSH, rand_addr(), rand_tick(), 1'b1);
            filled_addrs.delete();
        end
    endtask

    initial
    begin
        int  phase;
        int  phase_start;
        int  n_fill;
        bit  first_episode;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = OP_READ;
        word_address = '0;
        current_tick = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        clear_shadow();
        sh_latency = LAT_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[r])
        begin
            send_item(stim_rows[r].op, stim_rows[r].addr, stim_rows[r].now,
                      !stim_rows[r].typed);
            if (stim_rows[r].typed)
                pending_results.insert(pending_results.size(),
                                       make_result(stim_rows[r].exp_tick,
                                                   stim_rows[r].exp_status,
                                                   '0, 1'b0, 1'b1));
        end

        phase         = 0;
        first_episode = 1'b1;
        while (n_items < N_ROWS + RANDOM_ITEMS)
        begin
            case (phase)
                0:       set_latency('0);
                1:       set_latency(LAT_MAX);
                2:       set_latency(LAT_W'($urandom_range(2, 40)));
                3:       set_latency(LAT_RESET);
                default: set_latency(LAT_W'($urandom_range(0, 65535)));
            endcase
            phase_start = n_items;
            while (n_items - phase_start < PHASE_ITEMS && n_items < N_ROWS + RANDOM_ITEMS)
            begin
                if (first_episode)
                begin
                    // overfill, write every filled address, then flush the full table
                    run_episode(DEPTH + 2, 1'b1, 1'b1);
                    first_episode = 1'b0;
                end
                else
                begin
                    n_fill = ($urandom_range(0, 5) == 0) ? $urandom_range(20, DEPTH + 1)
                                                         : $urandom_range(1, 8);
                    run_episode(n_fill, n_fill >= 20 && $urandom_range(0, 1) == 1,
                                $urandom_range(0, 4) != 0);
                end
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d items over %0d latency settings: %0d flushes, %0d writebacks,",
                 n_items, n_cfg, n_flush, n_wb);
        $display("%0d misses, %0d fills into a full table; %0d results checked, %0d mismatches.",
                 n_miss, n_full, n_results, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("** scratchpad_word_timing_table_top: PASSED **");
        else
            $display("** scratchpad_word_timing_table_top: FAILED **");
        $finish;
    end

endmodule
